// ===== design/tkps_pkg.sv =====
// Shared types and constants for the top-K pattern selector.
// No dependencies; every other design file imports this package.
package tkps_pkg;

    localparam int MAX_ENTRIES     = 8;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int ATTR_WIDTH      = 16;
    localparam int CNT_W           = 4;
    localparam int IDX_W           = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;
    localparam int PROD_W          = 49;

    localparam logic signed [31:0] Q_MOST_NEG = 32'sh8000_0000;

    localparam logic [2:0] OPC_PUSH  = 3'd0;
    localparam logic [2:0] OPC_POP   = 3'd1;
    localparam logic [2:0] OPC_EMIT  = 3'd2;
    localparam logic [2:0] OPC_TEST  = 3'd3;
    localparam logic [2:0] OPC_DRAIN = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_K_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd1;

    typedef enum logic [2:0] {
        K_PUSH, K_POP, K_EMIT, K_TEST, K_DRAIN, K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE, BK_INSERT, BK_TEST, BK_DRAIN
    } t_bk_state;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        attribute;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        t_kind                 kind;
        logic [ATTR_WIDTH-1:0] attribute;
        logic signed [31:0]    value;
    } t_cmd;

    typedef struct packed {
        logic               keep;
        logic signed [31:0] worst_score;
        logic [3:0]         entry_count;
        logic [31:0]        emitted_total;
        logic [15:0]        attr_out;
        logic               attr_valid;
        logic signed [31:0] score_out;
        logic               entry_end;
        logic               last;
        logic [1:0]         error;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  k_limit;
        logic [16:0] alpha_scale;
    } t_cfg;

    typedef logic [MAX_PATTERN_LEN-1:0][ATTR_WIDTH-1:0] t_row;

endpackage

// ===== design/tkps_front.sv =====
// Front end: two-word input queue that decodes each opcode into a command kind.
// Depends on tkps_pkg.
module tkps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  tkps_pkg::t_in_word i_in,
    output logic            o_cmd_valid,
    output tkps_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);
    import tkps_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_dec;
    logic       w_wr, w_rd;

    always_comb begin
        case (i_in.opcode)
            OPC_PUSH:  w_dec.kind = K_PUSH;
            OPC_POP:   w_dec.kind = K_POP;
            OPC_EMIT:  w_dec.kind = K_EMIT;
            OPC_TEST:  w_dec.kind = K_TEST;
            OPC_DRAIN: w_dec.kind = K_DRAIN;
            default:   w_dec.kind = K_NOP;
        endcase
        w_dec.attribute = i_in.attribute[ATTR_WIDTH-1:0];
        w_dec.value     = i_in.value;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= w_dec;
    end

endmodule

// ===== design/tkps_back.sv =====
// Back end: pattern stack, sorted entry store, prune test, drain sequencer
// and the two-word result queue. Depends on tkps_pkg.
module tkps_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tkps_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    input  tkps_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    output logic              o_empty,
    input  logic              i_pop,
    output tkps_pkg::t_out_word o_res
);
    import tkps_pkg::*;

    t_bk_state r_state, n_state;

    logic [ATTR_WIDTH-1:0] r_stack [MAX_PATTERN_LEN];
    logic [CNT_W-1:0]      r_stack_len, n_stack_len;
    logic signed [31:0]    r_scores [MAX_ENTRIES];
    logic [CNT_W-1:0]      r_lens [MAX_ENTRIES];
    t_row                  r_pats [MAX_ENTRIES];
    logic [CNT_W-1:0]      r_kept, n_kept;
    logic signed [31:0]    r_worst, n_worst;
    logic [31:0]           r_emits, n_emits;

    logic signed [31:0]        r_score;
    logic                      r_ins;
    logic signed [PROD_W-1:0]  r_prod;
    logic [CNT_W-1:0]          r_ent, n_ent;
    logic [MAX_PATTERN_LEN-1:0] r_used, n_used;
    logic [CNT_W-1:0]          r_acnt, n_acnt;

    t_out_word  r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_space, w_opop;
    logic       w_res_valid;
    t_out_word  w_res;

    logic             w_remove, w_insert, w_push_st, w_take;
    logic [CNT_W-1:0] w_effk, w_pos;
    logic [IDX_W-1:0] w_row_idx, w_min_idx;
    logic [ATTR_WIDTH-1:0] w_min_val;
    logic             w_min_found;
    logic [CNT_W-1:0] w_len;
    logic signed [PROD_W-1:0] w_rhs;

    assign w_space = (r_ocnt != 2'd2);
    assign w_opop  = i_pop && !o_empty;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

    always_comb begin
        if (i_cfg.k_limit == '0)
            w_effk = CNT_W'(1);
        else if (i_cfg.k_limit > CNT_W'(MAX_ENTRIES))
            w_effk = CNT_W'(MAX_ENTRIES);
        else
            w_effk = i_cfg.k_limit;
    end

    // insert position: number of kept scores not above the new one
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CNT_W'(i) < r_kept && r_scores[i] <= r_score) w_pos = w_pos + CNT_W'(1);
        end
    end

    // drain: smallest unused attribute of the current entry
    assign w_row_idx = IDX_W'(r_ent - CNT_W'(1));
    assign w_len     = r_lens[w_row_idx];
    always_comb begin
        w_min_idx   = '0;
        w_min_val   = '0;
        w_min_found = 1'b0;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            if (CNT_W'(j) < w_len && !r_used[j] &&
                (!w_min_found || r_pats[w_row_idx][j] < w_min_val)) begin
                w_min_found = 1'b1;
                w_min_val   = r_pats[w_row_idx][j];
                w_min_idx   = IDX_W'(j);
            end
        end
    end

    // worst score scaled to the product's Q33.16 point, sign kept
    assign w_rhs = {r_worst[31], r_worst, 16'h0000};

    always_comb begin
        n_state     = r_state;
        n_stack_len = r_stack_len;
        n_kept      = r_kept;
        n_worst     = r_worst;
        n_emits     = r_emits;
        n_ent       = r_ent;
        n_used      = r_used;
        n_acnt      = r_acnt;
        w_take      = 1'b0;
        w_remove    = 1'b0;
        w_insert    = 1'b0;
        w_push_st   = 1'b0;
        w_res_valid = 1'b0;
        w_res       = '0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && w_space) begin
                    w_take = 1'b1;
                    case (i_cmd.kind)
                        K_PUSH: begin
                            w_res_valid = 1'b1;
                            if (r_stack_len < CNT_W'(MAX_PATTERN_LEN)) begin
                                w_push_st   = 1'b1;
                                n_stack_len = r_stack_len + CNT_W'(1);
                            end else begin
                                w_res.error = ERR_OVERFLOW;
                            end
                        end
                        K_POP: begin
                            w_res_valid = 1'b1;
                            if (r_stack_len != '0) n_stack_len = r_stack_len - CNT_W'(1);
                            else w_res.error = ERR_UNDERFLOW;
                        end
                        K_EMIT: begin
                            if (r_kept >= w_effk && r_kept != '0 && r_worst < i_cmd.value) begin
                                w_remove = 1'b1;
                                n_kept   = r_kept - CNT_W'(1);
                            end
                            if (r_emits != 32'hFFFF_FFFF) n_emits = r_emits + 32'd1;
                            n_state = BK_INSERT;
                        end
                        K_TEST: n_state = BK_TEST;
                        K_DRAIN: begin
                            n_kept  = '0;
                            n_worst = Q_MOST_NEG;
                            n_ent   = r_kept;
                            n_used  = '0;
                            n_acnt  = '0;
                            if (r_kept == '0) w_res_valid = 1'b1;
                            else n_state = BK_DRAIN;
                        end
                        default: w_res_valid = 1'b1;
                    endcase
                end
            end
            BK_INSERT: begin
                if (w_space) begin
                    w_res_valid = 1'b1;
                    n_state     = BK_IDLE;
                    if (r_ins && r_kept < CNT_W'(MAX_ENTRIES)) begin
                        w_insert = 1'b1;
                        n_kept   = r_kept + CNT_W'(1);
                        n_worst  = (w_pos == '0) ? r_score : r_scores[0];
                    end
                end
            end
            BK_TEST: begin
                if (w_space) begin
                    w_res_valid = 1'b1;
                    w_res.keep  = (r_prod > w_rhs);
                    n_state     = BK_IDLE;
                end
            end
            BK_DRAIN: begin
                if (w_space) begin
                    w_res_valid     = 1'b1;
                    w_res.score_out = r_scores[w_row_idx];
                    if (w_len == '0) begin
                        w_res.entry_end = 1'b1;
                    end else begin
                        w_res.attr_out   = w_min_val;
                        w_res.attr_valid = 1'b1;
                        w_res.entry_end  = (r_acnt + CNT_W'(1) == w_len);
                        n_used           = r_used | (MAX_PATTERN_LEN'(1) << w_min_idx);
                        n_acnt           = r_acnt + CNT_W'(1);
                    end
                    if (w_res.entry_end) begin
                        n_ent  = r_ent - CNT_W'(1);
                        n_used = '0;
                        n_acnt = '0;
                        if (r_ent == CNT_W'(1)) n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
        w_res.worst_score   = n_worst;
        w_res.entry_count   = n_kept;
        w_res.emitted_total = n_emits;
        w_res.last          = (n_state == BK_IDLE);
    end

    assign o_cmd_take = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_stack_len <= '0;
            r_kept      <= '0;
            r_worst     <= Q_MOST_NEG;
            r_emits     <= '0;
            r_ent       <= '0;
            r_used      <= '0;
            r_acnt      <= '0;
            r_owp       <= 1'b0;
            r_orp       <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_stack_len <= n_stack_len;
            r_kept      <= n_kept;
            r_worst     <= n_worst;
            r_emits     <= n_emits;
            r_ent       <= n_ent;
            r_used      <= n_used;
            r_acnt      <= n_acnt;
            if (w_res_valid) r_owp <= !r_owp;
            if (w_opop) r_orp <= !r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_res_valid} - {1'b0, w_opop};
        end
    end

    // payload: stack, entry store, operand holding, result queue
    always_ff @(posedge i_clk) begin
        if (w_res_valid) r_oq[r_owp] <= w_res;
        if (w_push_st) r_stack[r_stack_len[IDX_W-1:0]] <= i_cmd.attribute;
        if (w_take) begin
            r_score <= i_cmd.value;
            r_ins   <= (r_kept < w_effk) || w_remove;
            r_prod  <= PROD_W'(i_cmd.value * $signed({1'b0, i_cfg.alpha_scale}));
        end
        // evict lowest: shift every row down by one
        if (w_remove) begin
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                r_scores[i-1] <= r_scores[i];
                r_lens[i-1]   <= r_lens[i];
                r_pats[i-1]   <= r_pats[i];
            end
        end
        // sorted insert: open a slot at the position and copy the stack
        if (w_insert) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (CNT_W'(i) == w_pos) begin
                    r_scores[i] <= r_score;
                    r_lens[i]   <= r_stack_len;
                    for (int j = 0; j < MAX_PATTERN_LEN; j++) r_pats[i][j] <= r_stack[j];
                end else if (i > 0 && CNT_W'(i) > w_pos && CNT_W'(i) <= r_kept) begin
                    r_scores[i] <= r_scores[i-1];
                    r_lens[i]   <= r_lens[i-1];
                    r_pats[i]   <= r_pats[i-1];
                end
            end
        end
    end

endmodule

// ===== design/top_k_pattern_selector.sv =====
// Top-K pattern selector: a queue-style front end, an execution back end and
// the configuration registers. Depends on tkps_pkg, tkps_front, tkps_back.
//
// Items enter a two-word queue and are executed one at a time. Push, pop and
// unused opcodes write their result when the back end takes them; emit and
// test finish in a later back-end state (emit: evict then sorted insert; test:
// registered 32x17 product then compare). While the output queue has space,
// drain gives one result per cycle, one attribute per cycle (ascending, picked
// by a min search over the entry's row), entries best first. Results wait in
// a two-word output queue.
// Configuration (k_limit, alpha_scale) is always ready and must be written
// only while the block is idle.
module top_k_pattern_selector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  tkps_pkg::t_in_word         i_in,
    output logic                       o_empty,
    input  logic                       i_pop,
    output tkps_pkg::t_out_word        o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tkps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tkps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tkps_pkg::*;

    t_cfg r_cfg;
    logic w_cmd_valid, w_cmd_take;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k_limit     <= 4'd8;
            r_cfg.alpha_scale <= 17'h10000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_K_LIMIT: r_cfg.k_limit     <= i_cfg_data[3:0];
                REG_ALPHA:   r_cfg.alpha_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tkps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    tkps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_res       (o_res)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_res.entry_count <= 4'(MAX_ENTRIES))
        else $error("entry count above store size");

    a_drain_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.attr_valid) |->
            (o_res.entry_count == 4'd0 && o_res.worst_score == Q_MOST_NEG))
        else $error("drained word shows uncleared store");

endmodule
